// ----- sv/tsm_pkg.sv -----
// shared types and constants for the touch sample trimmed mean filter
package tsm_pkg;

  localparam int IN_W       = 12;
  localparam int OUT_W      = 12;
  localparam int CNT_W      = 4;
  localparam int MEAN_SHIFT = 3;
  localparam logic [CNT_W-1:0] BURST_LAST = CNT_W'(9);

  // per-axis control from the burst sequencer
  typedef struct packed {
    logic load;
    logic first;
    logic restart;
  } axis_ctl_t;

endpackage

// ----- sv/tsm_axis.sv -----
// one axis: running sum, min and max, and the trimmed mean of the burst
module tsm_axis #(
  parameter int ADC_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tsm_pkg::axis_ctl_t      ctl,
  input  logic [tsm_pkg::IN_W-1:0]  raw,
  output logic [tsm_pkg::OUT_W-1:0] filtered
);
  import tsm_pkg::*;

  localparam int SUM_W = ADC_BITS + 4;
  localparam logic [SUM_W-1:0] SMP_MASK = {{(SUM_W-ADC_BITS){1'b0}}, {ADC_BITS{1'b1}}};

  logic [SUM_W-1:0]    raw_ext;
  logic [ADC_BITS-1:0] smp;
  logic [SUM_W-1:0]    sum_r, sum_nxt, sum_add;
  logic [ADC_BITS-1:0] min_r, min_nxt;
  logic [ADC_BITS-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]    trim;
  logic [SUM_W-1:0]    mean;

  // bits above ADC_BITS are dropped
  assign raw_ext = SUM_W'(raw);
  assign smp     = raw_ext[ADC_BITS-1:0];

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.first) begin
      min_nxt = smp;
      max_nxt = smp;
    end else if (smp < min_r) begin
      min_nxt = smp;
    end else if (smp > max_r) begin
      max_nxt = smp;
    end
  end

  assign sum_add = sum_r + SUM_W'(smp);
  assign sum_nxt = ctl.restart ? '0 : sum_add;

  // after a burst's first word, min and max are two sum terms: no wrap
  assign trim     = sum_add - SUM_W'(min_nxt) - SUM_W'(max_nxt);
  assign mean     = (trim >> MEAN_SHIFT) & SMP_MASK;
  assign filtered = mean[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.load) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

// ----- sv/touch_sample_trimmed_mean.sv -----
// touch sample trimmed mean: input register, burst sequencer, two axes, result register
// an accepted word is held in the input register, then out_strobe rises from the result register
// throughput: one word per cycle, busy is low except the first cycle after reset
// a result is shown on out_* for one cycle with out_strobe; the receiver cannot stall
// reset (rst_n low, synchronous) clears the sample count, sums and all valid flags
// after reset a new burst starts; min and max are loaded by its first word
module touch_sample_trimmed_mean #(
  parameter int ADC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [tsm_pkg::IN_W-1:0]   in_x_sample,
  input  logic [tsm_pkg::IN_W-1:0]   in_y_sample,
  input  logic                       in_pen_down,
  output logic                       out_strobe,
  output logic [tsm_pkg::OUT_W-1:0]  out_x_filtered,
  output logic [tsm_pkg::OUT_W-1:0]  out_y_filtered,
  output logic                       out_success
);
  import tsm_pkg::*;

  logic              busy_r;
  logic              in_vld_r;
  logic [IN_W-1:0]   x_r, y_r;
  logic              pen_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              done, fail, emit;
  axis_ctl_t         ctl;
  logic [OUT_W-1:0]  x_mean, y_mean;
  logic              strobe_r, success_r;
  logic [OUT_W-1:0]  x_out_r, y_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      x_r   <= in_x_sample;
      y_r   <= in_y_sample;
      pen_r <= in_pen_down;
    end
  end

  // tenth word wins over pen release
  assign done = in_vld_r && (count_r == BURST_LAST);
  assign fail = in_vld_r && !done && !pen_r;
  assign emit = done || fail;

  assign count_nxt   = emit ? '0 : count_r + CNT_W'(1);
  assign ctl.load    = in_vld_r;
  assign ctl.first   = (count_r == '0);
  assign ctl.restart = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_vld_r) begin
      count_r <= count_nxt;
    end
  end

  tsm_axis #(.ADC_BITS(ADC_BITS)) u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .raw      (x_r),
    .filtered (x_mean)
  );

  tsm_axis #(.ADC_BITS(ADC_BITS)) u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .raw      (y_r),
    .filtered (y_mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      success_r <= done;
      x_out_r   <= done ? x_mean : '0;
      y_out_r   <= done ? y_mean : '0;
    end
  end

  assign busy           = busy_r;
  assign out_strobe     = strobe_r;
  assign out_success    = success_r;
  assign out_x_filtered = x_out_r;
  assign out_y_filtered = y_out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= BURST_LAST)
    else $error("sample count beyond burst length");

  a_restart_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> count_r == '0)
    else $error("burst not restarted after result");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_success) |-> (out_x_filtered == '0 && out_y_filtered == '0))
    else $error("failure result carries nonzero coordinates");

  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_vld_r))
    else $error("result strobe without a word in flight");

  a_accept_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> in_vld_r)
    else $error("accepted word lost before the accumulate stage");

endmodule
